/* design/tlbf_pkg.sv */
`default_nettype none

package tlbf_pkg;

  // Buffer geometry
  localparam int TlbEntries = 16;
  localparam int AddrBits   = 32;
  localparam int PageShift  = 10;
  localparam int IdxW       = $clog2(TlbEntries);
  localparam int PageW      = AddrBits - PageShift;

  // Stream field widths
  localparam int FieldW     = 32;
  localparam int SlotW      = 4;
  localparam int InDataW    = 3 * FieldW;
  localparam int OutRawW    = FieldW + SlotW;
  localparam int OutDataW   = ((OutRawW + 7) / 8) * 8;

  typedef enum logic {
    OpLookup = 1'b0,
    OpFill   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StScan,
    StFinish
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic commit;
    logic scan_start;
    logic scan_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_fill;
    logic any_free;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* design/tlbf_ctrl.sv */
`default_nettype none

module tlbf_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     req_valid_i,
  input  wire tlbf_pkg::status_t  status_i,
  output logic                    req_ready_o,
  output tlbf_pkg::cmd_t          cmd_o
);
  import tlbf_pkg::*;

  state_e state_q, state_d;

  // Advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) state_d = StLookup;
      end
      StLookup: begin
        if (status_i.op_fill && !status_i.any_free) begin
          state_d = StScan;
        end else if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      StScan: begin
        if (status_i.scan_last) state_d = StFinish;
      end
      StFinish: begin
        if (status_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o    = 1'b1;
        cmd_o.load_req = req_valid_i;
      end
      StLookup: begin
        if (status_i.op_fill && !status_i.any_free) begin
          cmd_o.scan_start = 1'b1;
        end else begin
          cmd_o.commit = status_i.out_free;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
      end
      StFinish: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/tlbf_datapath.sv */
`default_nettype none

module tlbf_datapath (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            op_i,
  input  wire  [tlbf_pkg::FieldW-1:0]    virtual_address_i,
  input  wire  [tlbf_pkg::FieldW-1:0]    fill_address_i,
  input  wire  [tlbf_pkg::FieldW-1:0]    timestamp_i,
  input  wire  tlbf_pkg::cmd_t           cmd_i,
  output tlbf_pkg::status_t              status_o,
  input  wire                            out_ready_i,
  output logic                           out_valid_o,
  output logic                           hit_o,
  output logic [tlbf_pkg::FieldW-1:0]    physical_address_o,
  output logic [tlbf_pkg::SlotW-1:0]     slot_o
);
  import tlbf_pkg::*;

  // Captured request
  logic                 req_op_q;
  logic [PageW-1:0]     req_page_q;
  logic [PageShift-1:0] req_off_q;
  logic [PageW-1:0]     req_frame_q;
  logic [FieldW-1:0]    req_ts_q;

  // Entry store
  logic [TlbEntries-1:0] valid_q;
  logic [PageW-1:0]      page_q    [TlbEntries];
  logic [PageW-1:0]      frame_q   [TlbEntries];
  logic [FieldW-1:0]     created_q [TlbEntries];

  // Oldest-entry scan
  logic [IdxW-1:0]   scan_cnt_q;
  logic [FieldW-1:0] best_q;
  logic [IdxW-1:0]   best_idx_q;

  // Result register
  logic              out_valid_q;
  logic              out_hit_q;
  logic [FieldW-1:0] out_pa_q;
  logic [SlotW-1:0]  out_slot_q;

  // Address masking to the configured width
  logic [AddrBits+FieldW-1:0] va_ext, fa_ext;
  logic [AddrBits-1:0]        va_m, fa_m;
  assign va_ext = {{AddrBits{1'b0}}, virtual_address_i};
  assign fa_ext = {{AddrBits{1'b0}}, fill_address_i};
  assign va_m   = va_ext[AddrBits-1:0];
  assign fa_m   = fa_ext[AddrBits-1:0];

  // Tag match and free-slot search
  logic [TlbEntries-1:0] match;
  logic                  any_match, any_free;
  logic [IdxW-1:0]       hit_idx, free_idx, target_idx;
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TlbEntries; i++) begin
      match[i] = valid_q[i] && (page_q[i] == req_page_q);
    end
    for (int i = TlbEntries - 1; i >= 0; i--) begin
      if (match[i])    hit_idx  = IdxW'(i);
      if (!valid_q[i]) free_idx = IdxW'(i);
    end
  end
  assign any_match  = |match;
  assign any_free   = ~&valid_q;
  assign target_idx = any_free ? free_idx : best_idx_q;

  // Translated address and slot fields
  logic [AddrBits-1:0]        pa_full;
  logic [AddrBits+FieldW-1:0] pa_ext;
  logic [IdxW+SlotW-1:0]      hit_slot_ext, tgt_slot_ext;
  assign pa_full      = {frame_q[hit_idx], req_off_q};
  assign pa_ext       = {{FieldW{1'b0}}, pa_full};
  assign hit_slot_ext = {{SlotW{1'b0}}, hit_idx};
  assign tgt_slot_ext = {{SlotW{1'b0}}, target_idx};

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.op_fill   = (req_op_q == OpFill);
  assign status_o.any_free  = any_free;
  assign status_o.scan_last = (scan_cnt_q == IdxW'(TlbEntries - 1));
  assign status_o.out_free  = out_free;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_op_q    <= op_i;
      req_page_q  <= va_m[AddrBits-1:PageShift];
      req_off_q   <= va_m[PageShift-1:0];
      req_frame_q <= fa_m[AddrBits-1:PageShift];
      req_ts_q    <= timestamp_i;
    end
  end

  // Walk the creation times, keeping the first strictly oldest
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      scan_cnt_q <= IdxW'(1);
      best_q     <= created_q[0];
      best_idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_cnt_q <= scan_cnt_q + IdxW'(1);
      if (created_q[scan_cnt_q] < best_q) begin
        best_q     <= created_q[scan_cnt_q];
        best_idx_q <= scan_cnt_q;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit && req_op_q == OpFill) begin
      valid_q[target_idx] <= 1'b1;
    end
  end

  // Install the entry on fill
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && req_op_q == OpFill) begin
      page_q[target_idx]    <= req_page_q;
      frame_q[target_idx]   <= req_frame_q;
      created_q[target_idx] <= req_ts_q;
    end
  end

  // Result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (req_op_q == OpFill) begin
        out_hit_q  <= 1'b0;
        out_pa_q   <= '0;
        out_slot_q <= tgt_slot_ext[SlotW-1:0];
      end else begin
        out_hit_q  <= any_match;
        out_pa_q   <= any_match ? pa_ext[FieldW-1:0] : '0;
        out_slot_q <= any_match ? hit_slot_ext[SlotW-1:0] : '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = out_hit_q;
  assign physical_address_o = out_pa_q;
  assign slot_o             = out_slot_q;

endmodule

`default_nettype wire

/* design/tlb_fifo_replacement.sv */
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: virtual, fill address, timestamp
//                                              tuser: operation
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: physical address, slot
//                                              tuser: hit
//
// A lookup, and a fill that finds a free slot, capture the request and then
// register the parallel tag compare in the output register once it is free.
// A fill into a full buffer first runs the oldest-entry search, which walks
// the creation-time registers one entry a cycle. One request is in flight at
// a time; a finished result waits in the output register while the next
// request is accepted, and a stalled output holds the commit of the
// following one. Reset clears the valid bits and all control.
`default_nettype none

module tlb_fifo_replacement (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] virtual_address, [63:32] fill_address, [95:64] timestamp
  input  wire  [tlbf_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] operation
  input  wire                              s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [31:0] physical_address, [35:32] slot, upper bits zero
  output logic [tlbf_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] hit
  output logic                             m_axis_tuser
);
  import tlbf_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [FieldW-1:0] pa;
  logic [SlotW-1:0]  slot;

  tlbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .status_i    (status),
    .req_ready_o (s_axis_tready),
    .cmd_o       (cmd)
  );

  tlbf_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (s_axis_tuser),
    .virtual_address_i  (s_axis_tdata[FieldW-1:0]),
    .fill_address_i     (s_axis_tdata[2*FieldW-1:FieldW]),
    .timestamp_i        (s_axis_tdata[3*FieldW-1:2*FieldW]),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .hit_o              (m_axis_tuser),
    .physical_address_o (pa),
    .slot_o             (slot)
  );

  assign m_axis_tdata = {{(OutDataW - OutRawW){1'b0}}, slot, pa};

endmodule

`default_nettype wire

/* design/tlbf_checker.sv */
`default_nettype none

module tlbf_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire [tlbf_pkg::InDataW-1:0]     s_axis_tdata,
  input wire                             s_axis_tuser,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [tlbf_pkg::OutDataW-1:0]    m_axis_tdata,
  input wire                             m_axis_tuser
);
  import tlbf_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // One request in flight: the input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // A miss or a fill never carries an address
  a_no_hit_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[FieldW-1:0] == '0))
    else $error("address on a result without a hit");

  // Padding above the slot stays clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:OutRawW] == '0))
    else $error("result padding not zero");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

endmodule

bind tlb_fifo_replacement tlbf_checker u_tlbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
